FILE: rtl/mean_median_mode_stats_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mean/median/mode statistics unit
// Checks are compiled in unless SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MEAN_MEDIAN_MODE_STATS_UNIT_MACROS_SVH
`define MEAN_MEDIAN_MODE_STATS_UNIT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define MMMS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mmms assertion failed");
// antecedent in one cycle implies consequent in the next
`define MMMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmms assertion failed");
`else
`define MMMS_ASSERT(label, prop)
`define MMMS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/mmms_pkg.sv
// ----------------------------------------------------------------------------
// mmms_pkg
// Constants and widths shared by the mean/median/mode statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mmms_pkg;

	// data range and set capacity
	localparam int VALUE_RANGE = 64;
	localparam int MAX_ITEMS   = 1024;

	// field widths
	localparam int VAL_W   = 6;
	localparam int ADDR_W  = $clog2(VALUE_RANGE);
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W   = $clog2(MAX_ITEMS * (VALUE_RANGE - 1) + 1);
	localparam int MODES_W = 7;
	localparam int FREQ_W  = 11;
	localparam int MEAN_W  = 14;
	localparam int MED_W   = 7;

	// mean divider: (sum << 8) / count, one quotient bit a step
	localparam int FRAC_W  = 8;
	localparam int DVD_W   = SUM_W + FRAC_W;
	localparam int STEP_W  = $clog2(DVD_W);

endpackage

`default_nettype wire

FILE: rtl/mean_median_mode_stats_unit.sv
// ----------------------------------------------------------------------------
// mean_median_mode_stats_unit
// Histogram based statistics over sets of small unsigned values: mean,
// median, highest frequency and the list of modes, one result per mode.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  item    | item_valid/item_ready  | value, last
//  res     | res_valid/res_ready    | mode_value, mode_count, max_freq,
//          |                        | mean_x256, median_x2, overflowed,
//          |                        | final_res
//
//  An element is a histogram read, then the incremented write.
//  A set end adds a bin scan (max, mode count, median), a divider pass for
//  the mean, then a mode sweep that reads and checks each bin and holds each
//  result until res_ready takes it.
//  Reset clears control state and the per-bin valid bits; no clearing pass.
//  item_ready is low while an element or a set's results are in progress.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mean_median_mode_stats_unit_macros.svh"

module mean_median_mode_stats_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic [mmms_pkg::VAL_W-1:0]   value,
	input  wire logic                         last,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic [mmms_pkg::VAL_W-1:0]        mode_value,
	output logic [mmms_pkg::MODES_W-1:0]      mode_count,
	output logic [mmms_pkg::FREQ_W-1:0]       max_freq,
	output logic [mmms_pkg::MEAN_W-1:0]       mean_x256,
	output logic [mmms_pkg::MED_W-1:0]        median_x2,
	output logic                              overflowed,
	output logic                              final_res
);
	import mmms_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_SCAN,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT_CHK,
		ST_EMIT_OUT
	} state_t;

	state_t state_q;

	// histogram RAM and per-bin valid bits
	logic [CNT_W-1:0]       hist_mem [VALUE_RANGE];
	logic [VALUE_RANGE-1:0] bin_vld_q;
	logic [CNT_W-1:0]       rd_data_q;
	logic                   rd_vld_q;
	logic [ADDR_W-1:0]      rd_addr;
	logic                   wr_en;
	logic [CNT_W-1:0]       wr_data;

	// set accumulators
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic              drop_q;
	logic [VAL_W-1:0]  val_q;
	logic              last_q;

	// sweep control
	logic [ADDR_W-1:0] addr_q;
	logic              issue_done_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] idx_s1;

	// scan results
	logic [FREQ_W-1:0]  maxf_q;
	logic [MODES_W-1:0] nmodes_q;
	logic [CNT_W-1:0]   acc_q;
	logic               f1_q, f2_q;
	logic [ADDR_W-1:0]  v1_q, v2_q;
	logic [MODES_W-1:0] k_q;

	// divider
	logic [DVD_W-1:0]  dq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic [MEAN_W-1:0] mean_q;

	// output registers
	logic              res_valid_q;
	logic [VAL_W-1:0]  mode_value_q;
	logic [MODES_W-1:0] mode_count_q;
	logic [FREQ_W-1:0] max_freq_q;
	logic [MEAN_W-1:0] mean_x256_q;
	logic [MED_W-1:0]  median_x2_q;
	logic              overflowed_q;
	logic              final_res_q;

	// combinational helpers
	logic              drop_now;
	logic [CNT_W-1:0]  cnt_next;
	logic [CNT_W-1:0]  hist_rd;
	logic [CNT_W-1:0]  acc_next;
	logic [CNT_W-1:0]  rank1, rank2;
	logic [CNT_W:0]    rem_sh;
	logic              q_bit;
	logic              item_acc, res_acc;
	logic [MED_W-1:0]  med2;

	assign item_ready = (state_q == ST_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign res_acc    = res_valid_q && res_ready;

	// element drop check and post-update count
	assign drop_now = ({1'b0, val_q} >= (VAL_W+1)'(VALUE_RANGE)) ||
	                  (cnt_q >= CNT_W'(MAX_ITEMS));
	assign cnt_next = drop_now ? cnt_q : cnt_q + 1'b1;

	// histogram bin as read, zero if not written in this set
	assign hist_rd  = rd_vld_q ? rd_data_q : '0;
	assign acc_next = acc_q + hist_rd;
	assign rank1    = (cnt_q - 1'b1) >> 1;
	assign rank2    = cnt_q >> 1;
	assign med2     = MED_W'(v1_q) + MED_W'(v2_q);

	// restoring divider step
	assign rem_sh = {rem_q, dq_q[DVD_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, cnt_q});

	// RAM port control
	always_comb begin
		rd_addr = addr_q;
		if (state_q == ST_IDLE) begin
			rd_addr = value;
		end
		wr_en   = (state_q == ST_INC) && !drop_now;
		wr_data = hist_rd + 1'b1;
	end

	// histogram RAM, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[val_q] <= wr_data;
		end
		rd_data_q <= hist_mem[rd_addr];
	end

	// sequencer, accumulators and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bin_vld_q    <= '0;
			rd_vld_q     <= 1'b0;
			cnt_q        <= '0;
			sum_q        <= '0;
			drop_q       <= 1'b0;
			pend_s1      <= 1'b0;
			issue_done_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			rd_vld_q <= bin_vld_q[rd_addr];
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						val_q   <= value;
						last_q  <= last;
						state_q <= ST_INC;
					end
				end
				ST_INC: begin
					if (drop_now) begin
						drop_q <= 1'b1;
					end else begin
						bin_vld_q[val_q] <= 1'b1;
						cnt_q            <= cnt_next;
						sum_q            <= sum_q + SUM_W'(val_q);
					end
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (cnt_next == '0) begin
						// empty set: a single all-zero result
						mode_value_q <= '0;
						mode_count_q <= '0;
						max_freq_q   <= '0;
						mean_x256_q  <= '0;
						median_x2_q  <= '0;
						overflowed_q <= drop_now || drop_q;
						final_res_q  <= 1'b1;
						res_valid_q  <= 1'b1;
						state_q      <= ST_EMIT_OUT;
					end else begin
						addr_q       <= '0;
						issue_done_q <= 1'b0;
						maxf_q       <= '0;
						nmodes_q     <= '0;
						acc_q        <= '0;
						f1_q         <= 1'b0;
						f2_q         <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue one bin read a cycle
					pend_s1 <= !issue_done_q;
					if (!issue_done_q) begin
						idx_s1  <= addr_q;
						addr_q  <= addr_q + 1'b1;
						if (addr_q == ADDR_W'(VALUE_RANGE - 1)) begin
							issue_done_q <= 1'b1;
						end
					end
					// process the bin read last cycle
					if (pend_s1) begin
						acc_q <= acc_next;
						if (!f1_q && (acc_next > rank1)) begin
							f1_q <= 1'b1;
							v1_q <= idx_s1;
						end
						if (!f2_q && (acc_next > rank2)) begin
							f2_q <= 1'b1;
							v2_q <= idx_s1;
						end
						if (FREQ_W'(hist_rd) > maxf_q) begin
							maxf_q   <= FREQ_W'(hist_rd);
							nmodes_q <= MODES_W'(1);
						end else if ((FREQ_W'(hist_rd) == maxf_q) && (hist_rd != '0)) begin
							nmodes_q <= nmodes_q + 1'b1;
						end
						if (idx_s1 == ADDR_W'(VALUE_RANGE - 1)) begin
							dq_q    <= {sum_q, FRAC_W'(0)};
							rem_q   <= '0;
							step_q  <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					// one quotient bit a cycle
					rem_q <= q_bit ? CNT_W'(rem_sh - {1'b0, cnt_q}) : CNT_W'(rem_sh);
					dq_q  <= {dq_q[DVD_W-2:0], q_bit};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DVD_W - 1)) begin
						mean_q  <= MEAN_W'({dq_q[DVD_W-2:0], q_bit});
						addr_q  <= '0;
						k_q     <= '0;
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_CHK;
				end
				ST_EMIT_CHK: begin
					if (FREQ_W'(hist_rd) == maxf_q) begin
						mode_value_q <= VAL_W'(addr_q);
						mode_count_q <= nmodes_q;
						max_freq_q   <= maxf_q;
						mean_x256_q  <= mean_q;
						median_x2_q  <= med2;
						overflowed_q <= drop_q;
						final_res_q  <= (k_q + 1'b1) == nmodes_q;
						res_valid_q  <= 1'b1;
						state_q      <= ST_EMIT_OUT;
					end else begin
						addr_q  <= addr_q + 1'b1;
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_OUT: begin
					if (res_acc) begin
						res_valid_q <= 1'b0;
						if (final_res_q) begin
							// set done: clear for the next one
							bin_vld_q <= '0;
							cnt_q     <= '0;
							sum_q     <= '0;
							drop_q    <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							addr_q  <= addr_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign mode_value = mode_value_q;
	assign mode_count = mode_count_q;
	assign max_freq   = max_freq_q;
	assign mean_x256  = mean_x256_q;
	assign median_x2  = median_x2_q;
	assign overflowed = overflowed_q;
	assign final_res  = final_res_q;

	// checks
	`MMMS_ASSERT(a_no_overlap, !(item_ready && res_valid))
	`MMMS_ASSERT(a_cnt_cap, cnt_q <= CNT_W'(MAX_ITEMS))
	`MMMS_ASSERT_NEXT(a_final_idle, res_valid && res_ready && final_res, item_ready && cnt_q == '0)
	`MMMS_ASSERT(a_mode_freq, !(res_valid && !final_res) || (max_freq != '0))
	`MMMS_ASSERT(a_mode_idx, !(state_q == ST_EMIT_CHK) || (k_q < nmodes_q))

endmodule

`default_nettype wire
